>>> rtl/kwrd_pkg.sv
// Shared types and fixed widths for the word-by-rank digit generator.
// No dependencies; used by kwrd_divider and kth_word_radix_digits_core.
package kwrd_pkg;

  localparam int unsigned IndexW = 64;   // rank / running quotient width
  localparam int unsigned RadixW = 16;   // alphabet size width
  localparam int unsigned LenW   = 7;    // word length register width
  localparam int unsigned StepW  = 6;    // bit counter of the serial divider
  localparam int unsigned ApbAw  = 3;
  localparam int unsigned ApbDw  = 32;

  localparam logic [LenW-1:0]   LenReset   = 7'd8;
  localparam logic [RadixW-1:0] RadixReset = 16'd2;

  // register index, taken from paddr[2]
  localparam logic RegAlphabet = 1'b0;
  localparam logic RegLength   = 1'b1;

  typedef struct packed {
    logic load;   // take a new dividend
    logic start;  // begin one full division by the radix
  } div_ctrl_t;

endpackage

>>> rtl/kwrd_divider.sv
// Bit-serial restoring divider: divides the running quotient by the radix,
// one quotient bit per cycle. Depends on kwrd_pkg.
module kwrd_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kwrd_pkg::div_ctrl_t             ctrl_i,
  input  logic [kwrd_pkg::IndexW-1:0]     dividend_i,
  input  logic [kwrd_pkg::RadixW-1:0]     divisor_i,
  output logic                            done_o,
  output logic [kwrd_pkg::IndexW-1:0]     quotient_o,
  output logic [kwrd_pkg::RadixW-1:0]     remainder_o
);

  logic [kwrd_pkg::IndexW-1:0] quo_q, quo_d;
  logic [kwrd_pkg::RadixW-1:0] rem_q, rem_d;
  logic [kwrd_pkg::StepW-1:0]  step_q, step_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [kwrd_pkg::RadixW:0]   trial;
  logic [kwrd_pkg::RadixW:0]   diff;
  logic                        fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[kwrd_pkg::IndexW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      if (ctrl_i.load) begin
        quo_d = dividend_i;
      end
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[kwrd_pkg::IndexW-2:0], fits};
      rem_d  = fits ? diff[kwrd_pkg::RadixW-1:0] : trial[kwrd_pkg::RadixW-1:0];
      step_d = step_q + kwrd_pkg::StepW'(1);
      if (step_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> rtl/kwrd_digit_mem.sv
// Digit buffer: one write port, one read port with registered read data.
// No package dependencies.
module kwrd_digit_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 16,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [Aw-1:0]    wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [Aw-1:0]    rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/kth_word_radix_digits_core.sv
// Word-by-rank generator: emits the base-N digits (plus one) of k-1, most
// significant first. The bit-serial divider produces each digit by one full
// division by the radix, and the remainder is stored in the digit buffer; each
// symbol is then read back from the buffer through the S_RD and S_LD states,
// where an output stall holds S_LD. Reset (rst_ni low, asynchronous) returns
// to idle, sets alphabet_size to 2 and word_length to 8. Depends on kwrd_pkg.
module kth_word_radix_digits_core #(
  parameter int unsigned MAX_LENGTH = 64,
  parameter int unsigned DIGIT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kwrd_pkg::ApbAw-1:0]        paddr,
  input  logic [kwrd_pkg::ApbDw-1:0]        pwdata,
  output logic [kwrd_pkg::ApbDw-1:0]        prdata,
  output logic                              pready,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [kwrd_pkg::IndexW-1:0]       word_index_i,
  // symbol channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [DIGIT_BITS-1:0]             symbol_o,
  output logic                              last_symbol_o,
  output logic                              out_of_range_o
);

  localparam int unsigned CntW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned Aw   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_RD   = 4'b0100,
    S_LD   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [kwrd_pkg::RadixW-1:0] alpha_q, alpha_d;
  logic [kwrd_pkg::LenW-1:0]   wlen_q, wlen_d;
  logic [CntW-1:0]             len_q, len_d;
  logic [CntW-1:0]             len_sat;
  logic [CntW-1:0]             dig_cnt_q, dig_cnt_d;
  logic [CntW-1:0]             rd_idx_q, rd_idx_d;
  logic                        flag_q, flag_d;
  logic                        out_valid_q, out_valid_d;
  logic [DIGIT_BITS-1:0]       symbol_q, symbol_d;
  logic                        last_q, last_d;
  logic                        oor_q, oor_d;

  logic                        cfg_wr;
  logic                        in_xfer;
  logic                        out_free;
  logic [kwrd_pkg::RadixW-1:0] radix;

  kwrd_pkg::div_ctrl_t         div_ctrl;
  logic                        div_done;
  logic [kwrd_pkg::IndexW-1:0] div_quo;
  logic [kwrd_pkg::RadixW-1:0] div_rem;

  logic                        mem_wr;
  logic                        mem_rd;
  logic [DIGIT_BITS-1:0]       mem_rdata;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    alpha_d = alpha_q;
    wlen_d  = wlen_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        kwrd_pkg::RegAlphabet: alpha_d = pwdata[kwrd_pkg::RadixW-1:0];
        kwrd_pkg::RegLength:   wlen_d  = pwdata[kwrd_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      kwrd_pkg::RegAlphabet:
        prdata = {{(kwrd_pkg::ApbDw - kwrd_pkg::RadixW){1'b0}}, alpha_q};
      kwrd_pkg::RegLength:
        prdata = {{(kwrd_pkg::ApbDw - kwrd_pkg::LenW){1'b0}}, wlen_q};
      default: prdata = '0;
    endcase
  end

  // a zero alphabet acts as a radix of one
  assign radix   = (alpha_q == '0) ? kwrd_pkg::RadixW'(1) : alpha_q;
  assign len_sat = (wlen_q > kwrd_pkg::LenW'(MAX_LENGTH)) ? CntW'(MAX_LENGTH)
                                                          : CntW'(wlen_q);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    dig_cnt_d   = dig_cnt_q;
    rd_idx_d    = rd_idx_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && out_stall_i;
    symbol_d    = symbol_q;
    last_d      = last_q;
    oor_d       = oor_q;
    div_ctrl    = '0;
    mem_wr      = 1'b0;
    mem_rd      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && (len_sat != '0)) begin
          len_d          = len_sat;
          dig_cnt_d      = '0;
          div_ctrl.load  = 1'b1;
          div_ctrl.start = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          mem_wr    = 1'b1;
          dig_cnt_d = dig_cnt_q + CntW'(1);
          if ((dig_cnt_q + CntW'(1)) == len_q) begin
            // leftover quotient means k-1 does not fit in L digits
            flag_d   = (div_quo != '0);
            rd_idx_d = dig_cnt_q;
            state_d  = S_RD;
          end else begin
            div_ctrl.start = 1'b1;
          end
        end
      end
      S_RD: begin
        mem_rd  = 1'b1;
        state_d = S_LD;
      end
      S_LD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          symbol_d    = mem_rdata + DIGIT_BITS'(1);
          last_d      = (rd_idx_q == '0);
          oor_d       = flag_q;
          if (rd_idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - CntW'(1);
            state_d  = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alpha_q     <= kwrd_pkg::RadixReset;
      wlen_q      <= kwrd_pkg::LenReset;
      len_q       <= '0;
      dig_cnt_q   <= '0;
      rd_idx_q    <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      alpha_q     <= alpha_d;
      wlen_q      <= wlen_d;
      len_q       <= len_d;
      dig_cnt_q   <= dig_cnt_d;
      rd_idx_q    <= rd_idx_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    symbol_q <= symbol_d;
    last_q   <= last_d;
    oor_q    <= oor_d;
  end

  kwrd_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .dividend_i  (word_index_i - kwrd_pkg::IndexW'(1)),
    .divisor_i   (radix),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  kwrd_digit_mem #(
    .Depth (MAX_LENGTH),
    .Width (DIGIT_BITS)
  ) u_digit_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr),
    .wr_addr_i (dig_cnt_q[Aw-1:0]),
    .wr_data_i (DIGIT_BITS'(div_rem)),
    .rd_en_i   (mem_rd),
    .rd_addr_i (rd_idx_q[Aw-1:0]),
    .rd_data_o (mem_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = symbol_q;
  assign last_symbol_o  = last_q;
  assign out_of_range_o = oor_q;

endmodule

>>> tb/tb_kth_word_radix_digits_core.sv
// Self-checking testbench for kth_word_radix_digits_core: a directed table,
// then randomized register settings and ranks, all checked per symbol transfer.
// Depends on kwrd_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_kth_word_radix_digits_core;

  localparam int unsigned MaxLen      = 64;
  localparam int unsigned RandomWords = 125;
  localparam int          RunLimitNs  = 20_000_000;

  typedef enum logic { RowCfg, RowReq } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        reg_sel;
    logic [31:0] data;
    logic [63:0] rank;
    bit          known;
    logic [15:0] sym;
    bit          oor;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
    logic        oor;
  } symbol_t;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        psel           = 1'b0;
  logic                        penable        = 1'b0;
  logic                        pwrite         = 1'b0;
  logic [kwrd_pkg::ApbAw-1:0]  paddr          = '0;
  logic [kwrd_pkg::ApbDw-1:0]  pwdata         = '0;
  logic [kwrd_pkg::ApbDw-1:0]  prdata;
  logic                        pready;
  logic                        in_valid_i     = 1'b0;
  logic                        in_stall_o;
  logic [kwrd_pkg::IndexW-1:0] word_index_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i    = 1'b0;
  logic [15:0]                 symbol_o;
  logic                        last_symbol_o;
  logic                        out_of_range_o;

  // local copy of the register file
  logic [15:0] cfg_alphabet = kwrd_pkg::RadixReset;
  logic [6:0]  cfg_length   = kwrd_pkg::LenReset;

  symbol_t  symbol_q [$];
  dir_row_t dir_tab [$];
  int       mismatches = 0;
  bit       idle_on    = 1'b1;

  kth_word_radix_digits_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .word_index_i  (word_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .symbol_o      (symbol_o),
    .last_symbol_o (last_symbol_o),
    .out_of_range_o(out_of_range_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned word_len();
    return (cfg_length > MaxLen) ? MaxLen : int'(cfg_length);
  endfunction

  function automatic logic [63:0] radix_eff();
    return (cfg_alphabet == 16'd0) ? 64'd1 : {48'd0, cfg_alphabet};
  endfunction

  // N^L, bit 64 set when it does not fit in 64 bits
  function automatic logic [64:0] word_space();
    logic [127:0] p;
    int unsigned  i;
    p = 128'd1;
    for (i = 0; i < word_len(); i++) begin
      p = p * {64'd0, radix_eff()};
      if (p[127:64] != 64'd0) return {1'b1, 64'd0};
    end
    return {1'b0, p[63:0]};
  endfunction

  // base-N expansion of k-1, most significant digit first
  task automatic predict_word(input logic [63:0] rank);
    logic [15:0] digits [MaxLen];
    logic [63:0] q;
    logic        oor;
    int unsigned n, i;
    n = word_len();
    q = rank - 64'd1;
    for (i = 0; i < n; i++) begin
      digits[i] = 16'(q % radix_eff());
      q = q / radix_eff();
    end
    oor = (q != 64'd0);
    for (i = 0; i < n; i++)
      symbol_q.push_back('{value: digits[n-1-i] + 16'd1, last: (i == n - 1), oor: oor});
  endtask

  task automatic queue_uniform(input logic [15:0] sym, input bit oor);
    int unsigned i;
    for (i = 0; i < word_len(); i++)
      symbol_q.push_back('{value: sym, last: (i == word_len() - 1), oor: oor});
  endtask

  task automatic add_row(input row_kind_e kind, input logic reg_sel, input logic [31:0] data,
                         input logic [63:0] rank, input bit known, input logic [15:0] sym,
                         input bit oor);
    dir_tab.push_back('{kind, reg_sel, data, rank, known, sym, oor});
  endtask

  // returns at the edge where the rank is transferred
  task automatic send_rank(input logic [63:0] rank);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    word_index_i <= rank;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  // drop valid, wait for every symbol, then let a possibly empty word finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (symbol_q.size() != 0) @(posedge clk_i);
    repeat (65 * word_len() + 40) @(posedge clk_i);
  endtask

  task automatic set_register(input logic reg_sel, input logic [31:0] data);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    if (reg_sel == kwrd_pkg::RegAlphabet) cfg_alphabet = data[15:0];
    else cfg_length = data[6:0];
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    want = (reg_sel == kwrd_pkg::RegAlphabet) ? {16'd0, cfg_alphabet} : {25'd0, cfg_length};
    if (prdata !== want) begin
      mismatches++;
      $display("%0t: register %0d read: expected %h actual %h", $time, reg_sel, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [63:0] draw_rank();
    logic [64:0] space;
    logic [63:0] r;
    int unsigned pick;
    space = word_space();
    r     = {$urandom, $urandom};
    pick  = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 2))
        0: r = 64'd0;
        1: r = 64'd1;
        default: r = '1;
      endcase
    end else if (pick >= 3 && !space[64]) begin
      // border of the range, or anywhere inside it
      if (pick == 3) r = space[63:0] + 64'($urandom_range(0, 1));
      else r = (r % space[63:0]) + 64'd1;
    end
    return r;
  endfunction

  initial begin : symbol_sink
    symbol_t     want;
    int unsigned hold;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      hold = idle_on ? $urandom_range(0, 10) : 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      if (symbol_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected symbol: expected none actual %h last %b oor %b",
                 $time, symbol_o, last_symbol_o, out_of_range_o);
      end else begin
        want = symbol_q.pop_front();
        if (symbol_o !== want.value) begin
          mismatches++;
          $display("%0t: symbol: expected %h actual %h", $time, want.value, symbol_o);
        end
        if (last_symbol_o !== want.last) begin
          mismatches++;
          $display("%0t: last_symbol: expected %b actual %b", $time, want.last, last_symbol_o);
        end
        if (out_of_range_o !== want.oor) begin
          mismatches++;
          $display("%0t: out_of_range: expected %b actual %b", $time, want.oor, out_of_range_o);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned random_words, n_items, j;
    logic [31:0] junk;
    logic [15:0] alpha;
    logic [6:0]  len;
    logic [63:0] rank;

    // reset values: N = 2, L = 8
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd1,   1'b1, 16'd1, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd256, 1'b1, 16'd2, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd257, 1'b1, 16'd1, 1'b1);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd0,   1'b1, 16'd2, 1'b1);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd100, 1'b0, 16'd0, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, '1,      1'b0, 16'd0, 1'b0);
    // widest alphabet, longest word; upper write bits are dropped
    add_row(RowCfg, kwrd_pkg::RegAlphabet, 32'hFFFF_FFFF, 64'd0, 1'b0, 16'd0, 1'b0);
    add_row(RowCfg, kwrd_pkg::RegLength,   32'hFFFF_FFC0, 64'd0, 1'b0, 16'd0, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd1, 1'b1, 16'd1, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd0, 1'b0, 16'd0, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, '1,    1'b0, 16'd0, 1'b0);
    // zero alphabet acts as a single symbol
    add_row(RowCfg, kwrd_pkg::RegAlphabet, 32'hFFFF_0000, 64'd0, 1'b0, 16'd0, 1'b0);
    add_row(RowCfg, kwrd_pkg::RegLength,   32'h0000_0001, 64'd0, 1'b0, 16'd0, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd1, 1'b1, 16'd1, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd2, 1'b1, 16'd1, 1'b1);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd0, 1'b1, 16'd1, 1'b1);
    // length above the maximum saturates
    add_row(RowCfg, kwrd_pkg::RegAlphabet, 32'h0000_0001, 64'd0, 1'b0, 16'd0, 1'b0);
    add_row(RowCfg, kwrd_pkg::RegLength,   32'h0000_007F, 64'd0, 1'b0, 16'd0, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd1, 1'b1, 16'd1, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd5, 1'b1, 16'd1, 1'b1);
    // zero length: no symbols at all
    add_row(RowCfg, kwrd_pkg::RegLength,   32'hFFFF_FF80, 64'd0, 1'b0, 16'd0, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd12345, 1'b0, 16'd0, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd0,     1'b0, 16'd0, 1'b0);
    add_row(RowCfg, kwrd_pkg::RegAlphabet, 32'h0000_000A, 64'd0, 1'b0, 16'd0, 1'b0);
    add_row(RowCfg, kwrd_pkg::RegLength,   32'h0000_0014, 64'd0, 1'b0, 16'd0, 1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd10000000000000000001, 1'b0, 16'd0,
            1'b0);
    add_row(RowReq, kwrd_pkg::RegAlphabet, 32'h0, 64'd0, 1'b0, 16'd0, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowCfg) begin
        settle();
        set_register(dir_tab[i].reg_sel, dir_tab[i].data);
      end else begin
        send_rank(dir_tab[i].rank);
        if (dir_tab[i].known) queue_uniform(dir_tab[i].sym, dir_tab[i].oor);
        else predict_word(dir_tab[i].rank);
      end
    end

    random_words = 0;
    while (random_words < RandomWords) begin
      settle();
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: alpha = 16'd0;
        1: alpha = 16'd1;
        2: alpha = 16'hFFFF;
        3: alpha = 16'($urandom_range(256, 65534));
        default: alpha = 16'($urandom_range(2, 16));
      endcase
      case ($urandom_range(0, 11))
        0: len = 7'd0;
        1: len = 7'd64;
        2: len = 7'($urandom_range(65, 127));
        3: len = 7'($urandom_range(20, 40));
        default: len = 7'($urandom_range(1, 10));
      endcase
      junk = $urandom;
      set_register(kwrd_pkg::RegAlphabet, {junk[31:16], alpha});
      junk = $urandom;
      set_register(kwrd_pkg::RegLength, {junk[31:7], len});
      n_items = (word_len() > 32 || word_len() == 0) ? 3 : $urandom_range(6, 14);
      for (j = 0; j < n_items; j++) begin
        rank = draw_rank();
        send_rank(rank);
        predict_word(rank);
        if (word_len() != 0) random_words++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(RunLimitNs);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
